@@ src/sva_pkg.sv @@
package sva_pkg;

  // Defaults for the top-level parameters
  localparam int VOICES_DEF      = 40;
  localparam int LENGTH_BITS_DEF = 20;

  // Fixed field widths of the stream items
  localparam int DRUM_W   = 6;
  localparam int AMP_W    = 16;
  localparam int START_W  = 12;
  localparam int LEN_W    = 20;
  localparam int VOICE_W  = 6;
  localparam int ADDR_W   = 20;
  localparam int KIND_W   = 2;
  localparam int TIME_W   = 32;

  // s_axis_tdata: drum_index, amplitude, start_offset, sample_length
  localparam int S_TDATA_W = 56;
  // m_axis_tdata: voice_number, fetch_drum, fetch_address, fetch_amplitude, was_stolen
  localparam int M_TDATA_W = 56;

  // Item selector on s_axis_tuser
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_TRIGGER = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_FETCH   = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_TRIGGER = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } seq_state_e;

  // Control into the shared compare unit
  typedef struct packed {
    logic trigger;   // 1: oldest-voice search, 0: playback update
    logic active;    // voice under evaluation is busy
    logic best_v;    // a best candidate is already held
  } unit_ctrl_t;

  // Status out of the shared compare unit
  typedef struct packed {
    logic fetch;     // voice plays a frame this tick
    logic keep;      // position still below end: advance, else free
    logic better;    // voice is busy and older than the held candidate, or none is held
  } unit_stat_t;

endpackage

@@ src/sample_voice_allocator.sv @@
// Voice engine of a polyphonic sample player. Two kinds of item arrive on the
// slave stream, told apart by s_axis_tuser. A note trigger takes the lowest-
// numbered free voice, or, with every voice busy, steals the voice that started
// earliest (lowest number on ties); it answers with one item (kind 2) that
// carries the voice number and the stolen flag. A frame tick walks all voices and
// emits one fetch item (kind 0: voice, drum, address, amplitude) for every busy
// voice whose position lies in [0, end), advances every busy voice that is below
// its end and frees the ones that reached it; a tick with nothing to play emits
// a single empty marker (kind 1). tlast marks the final item of each input.
// Per-voice state sits in a single-port-write, registered-read memory that one
// small compare unit visits one voice per cycle; the walk of a tick, and the
// answer to either item, can wait while the master side holds back an item. A
// trigger walks the voices up to and including the first free one (all of them
// when all are busy). s_axis_tready is high only between items. Reading a voice that
// was never triggered is outside the contract; only busy voices are ever read
// for output.
module sample_voice_allocator #(
  parameter int VOICES      = sva_pkg::VOICES_DEF,
  parameter int LENGTH_BITS = sva_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [5:0] drum_index, [21:6] amplitude, [33:22] start_offset, [53:34] sample_length
  input  logic [sva_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] func
  input  logic                            s_axis_tuser,
  // master side
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [5:0] voice_number, [11:6] fetch_drum, [31:12] fetch_address,
  // [47:32] fetch_amplitude, [48] was_stolen
  output logic [sva_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [1:0] result_kind
  output logic [sva_pkg::KIND_W-1:0]      m_axis_tuser,
  // last_of_frame
  output logic                            m_axis_tlast
);
  import sva_pkg::*;

  // Voice index width
  localparam int IdxW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  // Play position: signed, holds both the start offset range and the sample end
  localparam int PosW  = ((LENGTH_BITS > START_W - 1) ? LENGTH_BITS : START_W - 1) + 1;
  localparam int EndW  = LENGTH_BITS;
  // Memory word layout, lowest bits first: position, drum, gain, end, start time
  localparam int DrumO = PosW;
  localparam int GainO = DrumO + DRUM_W;
  localparam int EndO  = GainO + AMP_W;
  localparam int TimeO = EndO + EndW;
  localparam int MemW  = TimeO + TIME_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(VOICES - 1);

  // Sequencer
  seq_state_e state_q, state_d;
  logic [IdxW-1:0] idx_q;

  // Captured input item
  logic                func_q;
  logic [DRUM_W-1:0]   drum_q;
  logic [AMP_W-1:0]    amp_q;
  logic [START_W-1:0]  start_q;
  logic [LEN_W-1:0]    len_q;

  // Voice state outside the memory
  logic [VOICES-1:0]   active_q;
  logic [TIME_W-1:0]   frame_q;

  // Trigger search results
  logic                free_v_q;
  logic [IdxW-1:0]     free_idx_q;
  logic                best_v_q;
  logic [IdxW-1:0]     best_idx_q;
  logic [TIME_W-1:0]   best_q;

  // Pending fetch: held back until it is known whether it ends the frame
  logic                pend_v_q;
  logic [IdxW-1:0]     pend_voice_q;
  logic [DRUM_W-1:0]   pend_drum_q;
  logic [ADDR_W-1:0]   pend_addr_q;
  logic [AMP_W-1:0]    pend_amp_q;

  // Output register
  logic                out_v_q;
  result_kind_e        out_kind_q;
  logic [VOICE_W-1:0]  out_voice_q;
  logic [DRUM_W-1:0]   out_drum_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [AMP_W-1:0]    out_amp_q;
  logic                out_stolen_q;
  logic                out_last_q;

  // Memory port
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  logic [MemW-1:0]     mem_wdata;
  logic                mem_re;
  logic [IdxW-1:0]     mem_raddr;
  logic [MemW-1:0]     mem_rdata;

  // Fields of the voice under evaluation
  logic [PosW-1:0]     cur_pos;
  logic [DRUM_W-1:0]   cur_drum;
  logic [AMP_W-1:0]    cur_gain;
  logic [EndW-1:0]     cur_end;
  logic [TIME_W-1:0]   cur_time;
  logic                cur_active;

  // Shared unit
  unit_ctrl_t          u_ctrl;
  unit_stat_t          u_stat;
  logic [PosW-1:0]     pos_next;

  // Strobes
  logic                accept;
  logic                out_free;
  logic                eval;
  logic                finish;
  logic                out_load;
  logic                is_trig;
  logic [IdxW-1:0]     pick;
  logic [MemW-1:0]     new_rec;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_v_q || m_axis_tready;
  assign is_trig  = (func_q == FUNC_TRIGGER);

  assign cur_pos    = mem_rdata[PosW-1:0];
  assign cur_drum   = mem_rdata[DrumO +: DRUM_W];
  assign cur_gain   = mem_rdata[GainO +: AMP_W];
  assign cur_end    = mem_rdata[EndO +: EndW];
  assign cur_time   = mem_rdata[TimeO +: TIME_W];
  assign cur_active = active_q[idx_q];

  assign u_ctrl.trigger = is_trig;
  assign u_ctrl.active  = cur_active;
  assign u_ctrl.best_v  = best_v_q;

  assign pick    = free_v_q ? free_idx_q : best_idx_q;
  assign new_rec = {frame_q, EndW'(len_q), amp_q, drum_q, PosW'($signed(start_q))};

  sva_voice_unit #(
    .POS_W (PosW),
    .END_W (EndW)
  ) u_unit (
    .ctrl_i     (u_ctrl),
    .pos_i      (cur_pos),
    .end_i      (cur_end),
    .stime_i    (cur_time),
    .best_i     (best_q),
    .pos_next_o (pos_next),
    .stat_o     (u_stat)
  );

  sva_voice_mem #(
    .DEPTH (VOICES),
    .WIDTH (MemW),
    .AW    (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next state and memory control
  always_comb begin
    state_d   = state_q;
    mem_re    = 1'b0;
    mem_raddr = IdxW'(idx_q + IdxW'(1));
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {mem_rdata[MemW-1:PosW], pos_next};
    eval      = 1'b0;
    finish    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // Start the walk at voice zero
        if (accept) begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (is_trig) begin
          eval = 1'b1;
          // Stop at the first free voice
          if (!cur_active || idx_q == LastIdx) begin
            state_d = ST_FINISH;
          end else begin
            mem_re = 1'b1;
          end
        end else if (!(u_stat.fetch && pend_v_q) || out_free) begin
          // A new fetch pushes the pending one out; hold while the output is full
          eval   = 1'b1;
          mem_we = cur_active && u_stat.keep;
          if (idx_q == LastIdx) begin
            state_d = ST_FINISH;
          end else begin
            mem_re = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
          if (is_trig) begin
            mem_we    = 1'b1;
            mem_waddr = pick;
            mem_wdata = new_rec;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_load = (eval && !is_trig && u_stat.fetch && pend_v_q) || finish;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      active_q <= '0;
      frame_q  <= '0;
      free_v_q <= 1'b0;
      best_v_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        idx_q    <= '0;
        free_v_q <= 1'b0;
        best_v_q <= 1'b0;
        pend_v_q <= 1'b0;
      end else if (state_q == ST_SCAN && mem_re) begin
        idx_q <= mem_raddr;
      end
      if (eval && is_trig && !cur_active) begin
        free_v_q <= 1'b1;
      end
      if (eval && u_stat.better) begin
        best_v_q <= 1'b1;
      end
      // Drop voices that reached the end of their sample
      if (eval && !is_trig && cur_active && !u_stat.keep) begin
        active_q[idx_q] <= 1'b0;
      end
      if (eval && !is_trig && u_stat.fetch) begin
        pend_v_q <= 1'b1;
      end
      if (finish) begin
        pend_v_q <= 1'b0;
        if (is_trig) begin
          active_q[pick] <= 1'b1;
        end else begin
          frame_q <= frame_q + TIME_W'(1);
        end
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= s_axis_tuser;
      drum_q  <= s_axis_tdata[5:0];
      amp_q   <= s_axis_tdata[21:6];
      start_q <= s_axis_tdata[33:22];
      len_q   <= s_axis_tdata[53:34];
    end
    if (eval && is_trig && !cur_active) begin
      free_idx_q <= idx_q;
    end
    if (eval && u_stat.better) begin
      best_q     <= cur_time;
      best_idx_q <= idx_q;
    end
    if (eval && !is_trig && u_stat.fetch) begin
      pend_voice_q <= idx_q;
      pend_drum_q  <= cur_drum;
      pend_addr_q  <= ADDR_W'(cur_pos);
      pend_amp_q   <= cur_gain;
    end
    if (out_load) begin
      if (finish && is_trig) begin
        out_kind_q   <= KIND_TRIGGER;
        out_voice_q  <= VOICE_W'(pick);
        out_drum_q   <= '0;
        out_addr_q   <= '0;
        out_amp_q    <= '0;
        out_stolen_q <= !free_v_q;
        out_last_q   <= 1'b1;
      end else if (finish && !pend_v_q) begin
        // Silent tick: emit the empty marker
        out_kind_q   <= KIND_EMPTY;
        out_voice_q  <= '0;
        out_drum_q   <= '0;
        out_addr_q   <= '0;
        out_amp_q    <= '0;
        out_stolen_q <= 1'b0;
        out_last_q   <= 1'b1;
      end else begin
        // Release the held fetch; it is last only at the end of the walk
        out_kind_q   <= KIND_FETCH;
        out_voice_q  <= VOICE_W'(pend_voice_q);
        out_drum_q   <= pend_drum_q;
        out_addr_q   <= pend_addr_q;
        out_amp_q    <= pend_amp_q;
        out_stolen_q <= 1'b0;
        out_last_q   <= finish;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0, out_stolen_q, out_amp_q, out_addr_q, out_drum_q, out_voice_q};

endmodule

@@ src/sva_voice_mem.sv @@
module sva_voice_mem #(
  parameter int DEPTH = 40,
  parameter int WIDTH = 95,
  parameter int AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/sva_voice_unit.sv @@
module sva_voice_unit #(
  parameter int POS_W = 21,
  parameter int END_W = 20
) (
  input  sva_pkg::unit_ctrl_t       ctrl_i,
  input  logic [POS_W-1:0]          pos_i,
  input  logic [END_W-1:0]          end_i,
  input  logic [sva_pkg::TIME_W-1:0] stime_i,
  input  logic [sva_pkg::TIME_W-1:0] best_i,
  output logic [POS_W-1:0]          pos_next_o,
  output sva_pkg::unit_stat_t       stat_o
);
  import sva_pkg::*;

  localparam int CmpW = (POS_W + 1 > TIME_W + 1) ? POS_W + 1 : TIME_W + 1;

  logic signed [CmpW-1:0] op_a;
  logic signed [CmpW-1:0] op_b;
  logic                   lt;

  // One signed comparator serves both the age search and the end-of-sample check
  always_comb begin
    if (ctrl_i.trigger) begin
      op_a = CmpW'(stime_i);
      op_b = CmpW'(best_i);
    end else begin
      op_a = CmpW'($signed(pos_i));
      op_b = CmpW'(end_i);
    end
  end

  assign lt         = (op_a < op_b);
  assign pos_next_o = POS_W'(pos_i + POS_W'(1));

  always_comb begin
    stat_o.fetch  = !ctrl_i.trigger && ctrl_i.active && !pos_i[POS_W-1] && lt;
    stat_o.keep   = lt;
    stat_o.better = ctrl_i.trigger && ctrl_i.active && (!ctrl_i.best_v || lt);
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sva_pkg::*;

  localparam int VOICES       = VOICES_DEF;
  localparam int LENGTH_BITS  = LENGTH_BITS_DEF;
  localparam int PHASE_ITEMS  = 97;
  // One full voice sweep plus pipeline slack after the last result.
  localparam int DRAIN_CYCLES = VOICES + 8;
  // Worst case is ~410 items, each a tick with every voice fetching under heavy
  // master-side stall and sender gaps; allow that several times over.
  localparam int CYCLE_LIMIT  = 2_000_000;

  localparam logic [LEN_W-1:0] LEN_MASK = LEN_W'((64'd1 << LENGTH_BITS) - 1);

  // One item on the slave stream.
  typedef struct {
    logic                     func;
    logic [DRUM_W-1:0]        drum;
    logic [AMP_W-1:0]         amp;
    logic signed [START_W-1:0] start;
    logic [LEN_W-1:0]         len;
  } note_item_t;

  // One item on the master stream.
  typedef struct {
    result_kind_e      kind;
    logic [VOICE_W-1:0] voice;
    logic [DRUM_W-1:0]  drum;
    logic [ADDR_W-1:0]  addr;
    logic [AMP_W-1:0]   amp;
    logic               stolen;
    logic               last;
  } voice_result_t;

  // Shadow copy of the voice bank: predicts the items each accepted input
  // produces and checks them in order as they leave the block.
  class voice_bank_shadow;
    bit                 busy[VOICES];
    int                 position[VOICES];
    logic [DRUM_W-1:0]  drum_of[VOICES];
    logic [AMP_W-1:0]   gain_of[VOICES];
    logic [LEN_W-1:0]   end_of[VOICES];
    logic [TIME_W-1:0]  started_at[VOICES];
    logic [TIME_W-1:0]  frame_count;
    voice_result_t      awaited[$];
    int                 errors;

    function new();
      foreach (busy[v]) busy[v] = 1'b0;
      frame_count = '0;
      errors = 0;
    endfunction

    function voice_result_t make_result(result_kind_e kind, int voice,
                                        logic [DRUM_W-1:0] drum,
                                        logic [ADDR_W-1:0] addr,
                                        logic [AMP_W-1:0] amp, logic stolen);
      voice_result_t r;
      r.kind   = kind;
      r.voice  = VOICE_W'(voice);
      r.drum   = drum;
      r.addr   = addr;
      r.amp    = amp;
      r.stolen = stolen;
      r.last   = 1'b1;
      return r;
    endfunction

    // Advance the shadow bank by one accepted input and queue its results.
    function void take_note(note_item_t it);
      voice_result_t     batch[$];
      voice_result_t     r;
      int                pick;
      int                v;
      int                limit;
      logic              stolen;
      logic [TIME_W-1:0] oldest;
      if (it.func == FUNC_TRIGGER) begin
        pick = -1;
        stolen = 1'b0;
        for (v = 0; v < VOICES; v++) begin
          if (pick < 0 && !busy[v]) pick = v;
        end
        // All voices busy: take the earliest starter, lowest number on ties.
        if (pick < 0) begin
          pick = 0;
          oldest = started_at[0];
          for (v = 1; v < VOICES; v++) begin
            if (started_at[v] < oldest) begin
              oldest = started_at[v];
              pick = v;
            end
          end
          stolen = 1'b1;
        end
        busy[pick]       = 1'b1;
        position[pick]   = it.start;
        drum_of[pick]    = it.drum;
        gain_of[pick]    = it.amp;
        end_of[pick]     = it.len & LEN_MASK;
        started_at[pick] = frame_count;
        awaited.push_back(make_result(KIND_TRIGGER, pick, '0, '0, '0, stolen));
      end else begin
        for (v = 0; v < VOICES; v++) begin
          if (busy[v]) begin
            limit = int'(end_of[v]);
            // Negative positions are still counting down their delay.
            if (position[v] >= 0 && position[v] < limit) begin
              batch.push_back(make_result(KIND_FETCH, v, drum_of[v],
                                          ADDR_W'(position[v]), gain_of[v], 1'b0));
            end
            if (position[v] < limit) position[v]++;
            else busy[v] = 1'b0;
          end
        end
        if (batch.size() == 0) begin
          awaited.push_back(make_result(KIND_EMPTY, 0, '0, '0, '0, 1'b0));
        end else begin
          foreach (batch[i]) begin
            r = batch[i];
            r.last = (i == batch.size() - 1);
            awaited.push_back(r);
          end
        end
        frame_count++;
      end
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        errors++;
      end
    endfunction

    // Compare one item leaving the block with the oldest prediction.
    function void match_result(voice_result_t got);
      voice_result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected item: result_kind %0d voice_number %0d", got.kind, got.voice);
        errors++;
      end else begin
        want = awaited.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(got.kind));
        check_field("voice_number", 32'(want.voice), 32'(got.voice));
        check_field("fetch_drum", 32'(want.drum), 32'(got.drum));
        check_field("fetch_address", 32'(want.addr), 32'(got.addr));
        check_field("fetch_amplitude", 32'(want.amp), 32'(got.amp));
        check_field("was_stolen", 32'(want.stolen), 32'(got.stolen));
        check_field("last_of_frame", 32'(want.last), 32'(got.last));
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [KIND_W-1:0]     m_axis_tuser;
  logic                  m_axis_tlast;

  voice_bank_shadow bank;
  int               src_idle_pct;
  int               sink_stall_pct;
  int unsigned      cycle_count;

  sample_voice_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stall the master side at the rate of the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Sample every item leaving the block at the edge that accepts it.
  always @(posedge clk_i) begin : result_monitor
    voice_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind   = result_kind_e'(m_axis_tuser);
      got.voice  = m_axis_tdata[5:0];
      got.drum   = m_axis_tdata[11:6];
      got.addr   = m_axis_tdata[31:12];
      got.amp    = m_axis_tdata[47:32];
      got.stolen = m_axis_tdata[48];
      got.last   = m_axis_tlast;
      bank.match_result(got);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** sample_voice_allocator: FAILED **");
    $finish;
  end

  function automatic note_item_t note(logic func, logic [DRUM_W-1:0] drum,
                                      logic [AMP_W-1:0] amp, int start,
                                      logic [LEN_W-1:0] len);
    note_item_t it;
    it.func  = func;
    it.drum  = drum;
    it.amp   = amp;
    it.start = START_W'(start);
    it.len   = len;
    return it;
  endfunction

  // Mostly short notes that start and finish within the run, some long ones
  // that pile up until the bank is full and voices get stolen.
  function automatic note_item_t random_note();
    note_item_t it;
    int         pick;
    it.func = ($urandom_range(99) < 55) ? FUNC_TRIGGER : FUNC_TICK;
    it.drum = DRUM_W'($urandom_range(63));
    pick = $urandom_range(9);
    if (pick == 0) it.amp = '0;
    else if (pick == 1) it.amp = '1;
    else it.amp = AMP_W'($urandom);
    pick = $urandom_range(9);
    if (pick < 5) it.start = START_W'($urandom_range(8));
    else if (pick < 7) it.start = START_W'(-int'($urandom_range(6, 1)));
    else it.start = START_W'($urandom);
    pick = $urandom_range(19);
    if (pick < 10) it.len = LEN_W'($urandom_range(16));
    else if (pick < 15) it.len = LEN_W'($urandom_range(400, 17));
    else it.len = LEN_W'($urandom);
    return it;
  endfunction

  // Offer one item, idling first at the sender's rate; return once accepted.
  // Enter and leave right after a rising edge.
  task automatic send_item(input note_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.func;
    s_axis_tdata  <= S_TDATA_W'({it.len, it.start, it.amp, it.drum});
    do @(posedge clk_i); while (!s_axis_tready);
    bank.take_note(it);
  endtask

  // Hold the sender off until every predicted item has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (bank.awaited.size() != 0);
  endtask

  initial begin
    int phase;
    int n;
    bank           = new();
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = FUNC_TICK;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Silent bank: the tick answers with the empty marker.
    send_item(note(FUNC_TICK, 0, 0, 0, 0));
    // Zero-length sample: freed on the first tick without a fetch.
    send_item(note(FUNC_TRIGGER, 0, 16'h0000, 0, 0));
    send_item(note(FUNC_TICK, 0, 0, 0, 0));
    // Field extremes: top drum, full gain, latest start, longest sample.
    send_item(note(FUNC_TRIGGER, 63, 16'hFFFF, 2047, 20'hFFFFF));
    // Longest delay, then a one-frame delay that just reaches the end.
    send_item(note(FUNC_TRIGGER, 5, 16'h1234, -2048, 3));
    send_item(note(FUNC_TRIGGER, 10, 16'h8000, -1, 2));
    send_item(note(FUNC_TRIGGER, 1, 16'h0001, 0, 1));
    // Start exactly at the end: no fetch, freed.
    send_item(note(FUNC_TRIGGER, 2, 16'h7FFF, 5, 5));
    // Tick with every ignored data bit set.
    send_item(note(FUNC_TICK, 63, 16'hFFFF, -1, 20'hFFFFF));
    send_item(note(FUNC_TICK, 0, 0, 0, 0));
    send_item(note(FUNC_TICK, 0, 0, 0, 0));
    // Start past the end reuses a freed low voice.
    send_item(note(FUNC_TRIGGER, 42, 16'hAAAA, 3, 2));
    send_item(note(FUNC_TRIGGER, 21, 16'h5555, 0, 20'hFFFFF));
    send_item(note(FUNC_TICK, 0, 0, 0, 0));
    send_item(note(FUNC_TICK, 0, 0, 0, 0));
    send_item(note(FUNC_TRIGGER, 33, 16'h0000, 1, 4));
    send_item(note(FUNC_TICK, 0, 0, 0, 0));

    // Random phases: free run, sparse sender, stalling receiver, both idling.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 83;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 83;
        end
        default: begin
          src_idle_pct = 23;
          sink_stall_pct = 23;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) send_item(random_note());
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bank.errors == 0 && bank.awaited.size() == 0) begin
      $display("** sample_voice_allocator: PASSED **");
    end else begin
      $display("** sample_voice_allocator: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/sva_pkg.sv
src/sva_voice_mem.sv
src/sva_voice_unit.sv
src/sample_voice_allocator.sv
tb/tb_top.sv
